>>> hw/rtl/osc_packet_deframer_defines.svh
// Assertion macros used by the port-level checker file of the OSC deframer.
// Needs signals named clock and reset in the including scope.
`ifndef OSC_PACKET_DEFRAMER_DEFINES_SVH
`define OSC_PACKET_DEFRAMER_DEFINES_SVH

// same-cycle implication
`define OSD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("osd assertion failed");

// next-cycle implication
`define OSD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("osd assertion failed");

`endif

>>> hw/rtl/osd_pkg.sv
// Package of the OSC packet deframer: transaction types, codes, tables.
// No dependencies.
package osd_pkg;

   localparam int DEF_MAX_TAGS  = 16;
   localparam int DEF_MAX_DEPTH = 4;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       packet_last;
   } osd_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [2:0] byte_kind;
      logic [3:0] arg_number;
      logic [7:0] arg_type;
      logic       message_done;
      logic [2:0] nest_depth;
      logic [2:0] fault;
      logic       packet_done;
   } osd_rsp_type;

   localparam int MODE_W = 4;
   localparam logic [MODE_W-1:0] M_SCAN   = 4'd0;
   localparam logic [MODE_W-1:0] M_BHDR   = 4'd1;
   localparam logic [MODE_W-1:0] M_TIME   = 4'd2;
   localparam logic [MODE_W-1:0] M_ESIZE  = 4'd3;
   localparam logic [MODE_W-1:0] M_ADDR   = 4'd4;
   localparam logic [MODE_W-1:0] M_APAD   = 4'd5;
   localparam logic [MODE_W-1:0] M_TAG    = 4'd6;
   localparam logic [MODE_W-1:0] M_TPAD   = 4'd7;
   localparam logic [MODE_W-1:0] M_AFIX   = 4'd8;
   localparam logic [MODE_W-1:0] M_ASTR   = 4'd9;
   localparam logic [MODE_W-1:0] M_ASPAD  = 4'd10;
   localparam logic [MODE_W-1:0] M_BSIZE  = 4'd11;
   localparam logic [MODE_W-1:0] M_BDATA  = 4'd12;
   localparam logic [MODE_W-1:0] M_BPAD   = 4'd13;
   localparam logic [MODE_W-1:0] M_SKIPEL = 4'd14;

   localparam logic [2:0] KIND_SKIP  = 3'd0;
   localparam logic [2:0] KIND_BHDR  = 3'd1;
   localparam logic [2:0] KIND_TIME  = 3'd2;
   localparam logic [2:0] KIND_ESIZE = 3'd3;
   localparam logic [2:0] KIND_ADDR  = 3'd4;
   localparam logic [2:0] KIND_TAG   = 3'd5;
   localparam logic [2:0] KIND_ARG   = 3'd6;
   localparam logic [2:0] KIND_PAD   = 3'd7;

   localparam logic [2:0] FAULT_NONE    = 3'd0;
   localparam logic [2:0] FAULT_BUNDLE  = 3'd1;
   localparam logic [2:0] FAULT_TAGS    = 3'd2;
   localparam logic [2:0] FAULT_TRUNC   = 3'd3;
   localparam logic [2:0] FAULT_DEPTH   = 3'd4;

   localparam logic [2:0] CLS_NONE = 3'd0;
   localparam logic [2:0] CLS_FIX4 = 3'd1;
   localparam logic [2:0] CLS_FIX8 = 3'd2;
   localparam logic [2:0] CLS_STR  = 3'd3;
   localparam logic [2:0] CLS_BLOB = 3'd4;

   localparam logic [1:0] SE_CLEAN = 2'd0;
   localparam logic [1:0] SE_DONE  = 2'd1;
   localparam logic [1:0] SE_TRUNC = 2'd2;

   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_COMMA = 8'h2c;

   function automatic logic [2:0] tag_class(input logic [7:0] t);
      case (t)
         8'h69, 8'h66, 8'h63, 8'h72, 8'h6d: tag_class = CLS_FIX4;
         8'h68, 8'h74, 8'h64:               tag_class = CLS_FIX8;
         8'h73, 8'h53:                      tag_class = CLS_STR;
         8'h62:                             tag_class = CLS_BLOB;
         default:                           tag_class = CLS_NONE;
      endcase
   endfunction

   function automatic logic [7:0] bundle_byte(input logic [2:0] idx);
      case (idx)
         3'd0:    bundle_byte = CH_HASH;
         3'd1:    bundle_byte = 8'h62;
         3'd2:    bundle_byte = 8'h75;
         3'd3:    bundle_byte = 8'h6e;
         3'd4:    bundle_byte = 8'h64;
         3'd5:    bundle_byte = 8'h6c;
         3'd6:    bundle_byte = 8'h65;
         default: bundle_byte = 8'h00;
      endcase
   endfunction

endpackage

>>> hw/rtl/osd_core.sv
// Parser state and combinational byte labeling logic of the OSC deframer.
// Depends on osd_pkg.
module osd_core import osd_pkg::*; #(
   parameter int MAX_TAGS  = DEF_MAX_TAGS,
   parameter int MAX_DEPTH = DEF_MAX_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        step_en,
   input  osd_req_type req,
   output osd_rsp_type rsp
);

   localparam int TCW = $clog2(MAX_TAGS + 1);
   localparam int TIW = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
   localparam int DW  = $clog2(MAX_DEPTH + 1);
   localparam int DIW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [2:0]        hdr_ff, hdr_in;
   logic [31:0]       fbc_ff, fbc_in;
   logic [31:0]       shift_ff, shift_in;
   logic [1:0]        pad_ff, pad_in;
   logic [TCW-1:0]    tcnt_ff, tcnt_in;
   logic [TCW-1:0]    tcur_ff, tcur_in;
   logic [DW-1:0]     dep_ff, dep_in;
   logic [7:0]        tag_ff [MAX_TAGS];
   logic [31:0]       er_ff [MAX_DEPTH];
   logic [31:0]       er_in [MAX_DEPTH];

   logic              tag_we;
   logic [TIW-1:0]    tag_wa;
   logic [7:0]        tag_wd;
   logic [7:0]        b;
   logic [2:0]        kind_c;
   logic [TCW-1:0]    argn_c;
   logic [7:0]        argt_c;
   logic              done_c;
   logic [2:0]        fault_c;
   logic              again_c;
   logic              ending_c;
   logic [1:0]        code_c;
   logic [31:0]       s_c;
   logic [31:0]       r_c;
   logic [DW-1:0]     nd_c;

   function automatic logic [TCW-1:0] next_sized(input logic [TCW:0] start,
                                                 input logic [TCW-1:0] cnt);
      logic [TCW-1:0] res;
      logic           found;
      res   = cnt;
      found = 1'b0;
      for (int j = 0; j < MAX_TAGS; j++) begin
         if (!found && j >= start && j < cnt && tag_class(tag_ff[j]) != CLS_NONE) begin
            res   = TCW'(j);
            found = 1'b1;
         end
      end
      return res;
   endfunction

   function automatic void begin_args(input logic [TCW:0] start,
                                      input logic [TCW-1:0] cnt,
                                      inout logic [MODE_W-1:0] md,
                                      inout logic [TCW-1:0] cu,
                                      inout logic [31:0] fc,
                                      inout logic [31:0] sh,
                                      inout logic dn);
      logic [TCW-1:0] j;
      j = next_sized(start, cnt);
      if (j >= cnt) begin
         dn = 1'b1;
         md = M_SCAN;
      end else begin
         cu = j;
         fc = 32'd0;
         case (tag_class(tag_ff[TIW'(j)]))
            CLS_FIX4: begin
               md = M_AFIX;
               fc = 32'd4;
            end
            CLS_FIX8: begin
               md = M_AFIX;
               fc = 32'd8;
            end
            CLS_STR: md = M_ASTR;
            default: begin
               md = M_BSIZE;
               sh = 32'd0;
            end
         endcase
      end
   endfunction

   function automatic logic [1:0] scope_end(input logic [MODE_W-1:0] md,
                                            input logic [31:0] fc,
                                            input logic [TCW-1:0] cu,
                                            input logic [TCW-1:0] cnt);
      case (md)
         M_SCAN:  scope_end = SE_CLEAN;
         M_ESIZE: scope_end = (fc == 32'd0) ? SE_CLEAN : SE_TRUNC;
         M_APAD:  scope_end = SE_DONE;
         M_TPAD:  scope_end = (next_sized('0, cnt) >= cnt) ? SE_DONE : SE_TRUNC;
         M_ASPAD: scope_end = (next_sized({1'b0, cu} + 1'b1, cnt) >= cnt) ?
                              SE_DONE : SE_TRUNC;
         default: scope_end = SE_TRUNC;
      endcase
   endfunction

   always_comb begin
      b        = req.in_byte;
      mode_in  = mode_ff;
      hdr_in   = hdr_ff;
      fbc_in   = fbc_ff;
      shift_in = shift_ff;
      pad_in   = pad_ff;
      tcnt_in  = tcnt_ff;
      tcur_in  = tcur_ff;
      dep_in   = dep_ff;
      for (int k = 0; k < MAX_DEPTH; k++) er_in[k] = er_ff[k];
      tag_we   = 1'b0;
      tag_wa   = '0;
      tag_wd   = b;
      kind_c   = KIND_SKIP;
      argn_c   = '0;
      argt_c   = 8'd0;
      done_c   = 1'b0;
      fault_c  = FAULT_NONE;
      again_c  = 1'b1;
      ending_c = 1'b0;
      code_c   = SE_CLEAN;
      s_c      = 32'd0;
      r_c      = 32'd0;
      nd_c     = '0;

      if (dep_ff != '0 && er_in[DIW'(dep_ff - 1'b1)] != 32'd0) begin
         er_in[DIW'(dep_ff - 1'b1)] = er_in[DIW'(dep_ff - 1'b1)] - 32'd1;
         if (er_in[DIW'(dep_ff - 1'b1)] == 32'd0) ending_c = 1'b1;
      end

      for (int p = 0; p < 2; p++) begin
         if (again_c) begin
            again_c = 1'b0;
            if (mode_in inside {[M_AFIX:M_BPAD]} && tcur_in < MAX_TAGS) begin
               argn_c = tcur_in;
               argt_c = tag_ff[TIW'(tcur_in)];
            end else begin
               argn_c = '0;
               argt_c = 8'd0;
            end
            case (mode_in)
               M_SCAN: begin
                  if (b == CH_HASH) begin
                     kind_c  = KIND_BHDR;
                     mode_in = M_BHDR;
                     hdr_in  = 3'd1;
                  end else if (b == CH_SLASH) begin
                     kind_c  = KIND_ADDR;
                     mode_in = M_ADDR;
                     fbc_in  = 32'd1;
                  end else begin
                     kind_c = KIND_SKIP;
                  end
               end
               M_BHDR: begin
                  if (hdr_in < 3'd7 && b != bundle_byte(hdr_in)) begin
                     if (fault_c == FAULT_NONE) fault_c = FAULT_BUNDLE;
                     mode_in = M_SCAN;
                     again_c = 1'b1;
                  end else begin
                     kind_c = KIND_BHDR;
                     if (hdr_in >= 3'd7) begin
                        mode_in = M_TIME;
                        fbc_in  = 32'd0;
                     end else begin
                        hdr_in = hdr_in + 3'd1;
                     end
                  end
               end
               M_TIME: begin
                  kind_c = KIND_TIME;
                  fbc_in = fbc_in + 32'd1;
                  if (fbc_in >= 32'd8) begin
                     mode_in  = M_ESIZE;
                     fbc_in   = 32'd0;
                     shift_in = 32'd0;
                  end
               end
               M_ESIZE: begin
                  kind_c   = KIND_ESIZE;
                  shift_in = {shift_in[23:0], b};
                  fbc_in   = fbc_in + 32'd1;
                  if (fbc_in >= 32'd4) begin
                     s_c = shift_in[31] ? 32'd0 : shift_in;
                     r_c = (s_c + 32'd3) & ~32'd3;
                     if (dep_in != '0 && r_c > er_in[DIW'(dep_in - 1'b1)])
                        r_c = er_in[DIW'(dep_in - 1'b1)];
                     fbc_in   = 32'd0;
                     shift_in = 32'd0;
                     if (r_c != 32'd0) begin
                        if (dep_in >= MAX_DEPTH) begin
                           if (fault_c == FAULT_NONE) fault_c = FAULT_DEPTH;
                           mode_in = M_SKIPEL;
                           fbc_in  = r_c;
                        end else begin
                           if (dep_in != '0)
                              er_in[DIW'(dep_in - 1'b1)] = er_in[DIW'(dep_in - 1'b1)] - r_c;
                           er_in[DIW'(dep_in)] = r_c;
                           dep_in  = dep_in + 1'b1;
                           mode_in = M_SCAN;
                        end
                     end
                  end
               end
               M_ADDR: begin
                  if (b != 8'd0) begin
                     kind_c = KIND_ADDR;
                     fbc_in = fbc_in + 32'd1;
                  end else begin
                     kind_c  = KIND_PAD;
                     pad_in  = 2'd3 - fbc_in[1:0];
                     mode_in = M_APAD;
                  end
               end
               M_APAD: begin
                  if (b == 8'd0 && pad_in != 2'd0) begin
                     kind_c = KIND_PAD;
                     pad_in = pad_in - 2'd1;
                  end else if (b == CH_COMMA) begin
                     kind_c  = KIND_TAG;
                     mode_in = M_TAG;
                     fbc_in  = 32'd1;
                     tcnt_in = '0;
                     tcur_in = '0;
                  end else begin
                     done_c  = 1'b1;
                     mode_in = M_SCAN;
                     again_c = 1'b1;
                  end
               end
               M_TAG: begin
                  if (b != 8'd0) begin
                     kind_c = KIND_TAG;
                     fbc_in = fbc_in + 32'd1;
                     if (tcnt_in < MAX_TAGS) begin
                        tag_we  = 1'b1;
                        tag_wa  = TIW'(tcnt_in);
                        tcnt_in = tcnt_in + 1'b1;
                     end else if (fault_c == FAULT_NONE) begin
                        fault_c = FAULT_TAGS;
                     end
                  end else begin
                     kind_c  = KIND_PAD;
                     pad_in  = 2'd3 - fbc_in[1:0];
                     tcur_in = '0;
                     if (pad_in == 2'd0)
                        begin_args('0, tcnt_in, mode_in, tcur_in, fbc_in, shift_in, done_c);
                     else
                        mode_in = M_TPAD;
                  end
               end
               M_TPAD: begin
                  if (b == 8'd0 && pad_in != 2'd0) begin
                     kind_c = KIND_PAD;
                     pad_in = pad_in - 2'd1;
                     if (pad_in == 2'd0)
                        begin_args('0, tcnt_in, mode_in, tcur_in, fbc_in, shift_in, done_c);
                  end else begin
                     begin_args('0, tcnt_in, mode_in, tcur_in, fbc_in, shift_in, done_c);
                     again_c = 1'b1;
                  end
               end
               M_AFIX: begin
                  kind_c = KIND_ARG;
                  if (fbc_in != 32'd0) fbc_in = fbc_in - 32'd1;
                  if (fbc_in == 32'd0)
                     begin_args({1'b0, tcur_in} + 1'b1, tcnt_in, mode_in, tcur_in, fbc_in,
                                shift_in, done_c);
               end
               M_ASTR: begin
                  if (b != 8'd0) begin
                     kind_c = KIND_ARG;
                     fbc_in = fbc_in + 32'd1;
                  end else begin
                     kind_c = KIND_PAD;
                     pad_in = 2'd3 - fbc_in[1:0];
                     if (pad_in == 2'd0)
                        begin_args({1'b0, tcur_in} + 1'b1, tcnt_in, mode_in, tcur_in, fbc_in,
                                   shift_in, done_c);
                     else
                        mode_in = M_ASPAD;
                  end
               end
               M_ASPAD: begin
                  if (b == 8'd0 && pad_in != 2'd0) begin
                     kind_c = KIND_PAD;
                     pad_in = pad_in - 2'd1;
                     if (pad_in == 2'd0)
                        begin_args({1'b0, tcur_in} + 1'b1, tcnt_in, mode_in, tcur_in, fbc_in,
                                   shift_in, done_c);
                  end else begin
                     begin_args({1'b0, tcur_in} + 1'b1, tcnt_in, mode_in, tcur_in, fbc_in,
                                shift_in, done_c);
                     again_c = 1'b1;
                  end
               end
               M_BSIZE: begin
                  kind_c   = KIND_ARG;
                  shift_in = {shift_in[23:0], b};
                  fbc_in   = fbc_in + 32'd1;
                  if (fbc_in >= 32'd4) begin
                     s_c      = shift_in[31] ? 32'd0 : shift_in;
                     fbc_in   = s_c;
                     pad_in   = 2'd0 - s_c[1:0];
                     shift_in = 32'd0;
                     if (s_c != 32'd0)
                        mode_in = M_BDATA;
                     else if (pad_in != 2'd0)
                        mode_in = M_BPAD;
                     else
                        begin_args({1'b0, tcur_in} + 1'b1, tcnt_in, mode_in, tcur_in, fbc_in,
                                   shift_in, done_c);
                  end
               end
               M_BDATA: begin
                  kind_c = KIND_ARG;
                  if (fbc_in != 32'd0) fbc_in = fbc_in - 32'd1;
                  if (fbc_in == 32'd0) begin
                     if (pad_in != 2'd0)
                        mode_in = M_BPAD;
                     else
                        begin_args({1'b0, tcur_in} + 1'b1, tcnt_in, mode_in, tcur_in, fbc_in,
                                   shift_in, done_c);
                  end
               end
               M_BPAD: begin
                  kind_c = KIND_PAD;
                  if (pad_in != 2'd0) pad_in = pad_in - 2'd1;
                  if (pad_in == 2'd0)
                     begin_args({1'b0, tcur_in} + 1'b1, tcnt_in, mode_in, tcur_in, fbc_in,
                                shift_in, done_c);
               end
               M_SKIPEL: begin
                  kind_c = KIND_SKIP;
                  if (fbc_in != 32'd0) fbc_in = fbc_in - 32'd1;
                  if (fbc_in == 32'd0) begin
                     mode_in  = M_ESIZE;
                     shift_in = 32'd0;
                  end
               end
               default: begin
                  kind_c  = KIND_SKIP;
                  mode_in = M_SCAN;
               end
            endcase
         end
      end

      if (kind_c != KIND_ARG && kind_c != KIND_PAD) begin
         argn_c = '0;
         argt_c = 8'd0;
      end

      if (ending_c) begin
         code_c = scope_end(mode_in, fbc_in, tcur_in, tcnt_in);
         if (code_c == SE_DONE)
            done_c = 1'b1;
         else if (code_c == SE_TRUNC && fault_c == FAULT_NONE)
            fault_c = FAULT_TRUNC;
         for (int k = 0; k < MAX_DEPTH; k++) begin
            if (k + 1 < dep_ff && er_in[k] != 32'd0) nd_c = DW'(k + 1);
         end
         dep_in   = nd_c;
         mode_in  = M_ESIZE;
         fbc_in   = 32'd0;
         shift_in = 32'd0;
         pad_in   = 2'd0;
      end

      if (req.packet_last) begin
         code_c = scope_end(mode_in, fbc_in, tcur_in, tcnt_in);
         if (code_c == SE_DONE)
            done_c = 1'b1;
         else if ((code_c == SE_TRUNC || dep_in != '0) && fault_c == FAULT_NONE)
            fault_c = FAULT_TRUNC;
         mode_in  = M_SCAN;
         hdr_in   = 3'd0;
         fbc_in   = 32'd0;
         pad_in   = 2'd0;
         tcnt_in  = '0;
         tcur_in  = '0;
         dep_in   = '0;
         shift_in = 32'd0;
      end

      rsp.out_byte     = b;
      rsp.byte_kind    = kind_c;
      rsp.arg_number   = 4'(argn_c);
      rsp.arg_type     = argt_c;
      rsp.message_done = done_c;
      rsp.nest_depth   = 3'(dep_ff);
      rsp.fault        = fault_c;
      rsp.packet_done  = req.packet_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_SCAN;
         hdr_ff   <= 3'd0;
         fbc_ff   <= 32'd0;
         shift_ff <= 32'd0;
         pad_ff   <= 2'd0;
         tcnt_ff  <= '0;
         tcur_ff  <= '0;
         dep_ff   <= '0;
      end else if (step_en) begin
         mode_ff  <= mode_in;
         hdr_ff   <= hdr_in;
         fbc_ff   <= fbc_in;
         shift_ff <= shift_in;
         pad_ff   <= pad_in;
         tcnt_ff  <= tcnt_in;
         tcur_ff  <= tcur_in;
         dep_ff   <= dep_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en && tag_we) begin
         tag_ff[tag_wa] <= tag_wd;
      end
      if (step_en) begin
         for (int k = 0; k < MAX_DEPTH; k++) er_ff[k] <= er_in[k];
      end
   end

endmodule

>>> hw/rtl/osd_outreg.sv
// Result register of the OSC deframer; takes a new transaction while the
// held one is being taken. Depends on osd_pkg.
module osd_outreg import osd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        step_en,
   input  osd_rsp_type rsp_next,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output osd_rsp_type rsp_data
);

   logic        valid_ff, valid_in;
   osd_rsp_type data_ff;

   assign req_stall = valid_ff && rsp_stall;
   assign step_en   = req_valid && !req_stall;
   assign valid_in  = step_en || (valid_ff && rsp_stall);
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         data_ff <= rsp_next;
      end
   end

endmodule

>>> hw/rtl/osc_packet_deframer.sv
// Top level of the OSC packet deframer: byte labeling core plus result register.
// Depends on osd_pkg, osd_core, osd_outreg.
//
//   channel  dir  handshake             payload
//   req_     in   req_valid/req_stall   osd_req_type  (byte, end of packet)
//   rsp_     out  rsp_valid/rsp_stall   osd_rsp_type  (byte and its labels)
//
// One byte per cycle while req_stall is low; each result appears in the cycle after its byte is taken.
// Latency is set by the single result register after the labeling logic.
// Reset is synchronous; parser state returns to top-level scan.
// A stalled result holds; req_stall rises only while a result waits stalled.
module osc_packet_deframer import osd_pkg::*; #(
   parameter int MAX_TAGS  = DEF_MAX_TAGS,
   parameter int MAX_DEPTH = DEF_MAX_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  osd_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output osd_rsp_type rsp_data
);

   logic        step_en;
   osd_rsp_type rsp_next;

   osd_core #(
      .MAX_TAGS  (MAX_TAGS),
      .MAX_DEPTH (MAX_DEPTH)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .req     (req_data),
      .rsp     (rsp_next)
   );

   osd_outreg u_outreg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .step_en   (step_en),
      .rsp_next  (rsp_next),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> hw/rtl/osd_checker.sv
// Port-level assertions for the OSC packet deframer, bound to its top level.
// Depends on osd_pkg and osc_packet_deframer_defines.svh.
`include "osc_packet_deframer_defines.svh"

module osd_checker import osd_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input osd_req_type req_data,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input osd_rsp_type rsp_data
);

   `OSD_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)
   `OSD_ASSERT_NEXT(a_echo, req_valid && !req_stall, rsp_valid && rsp_data.out_byte == $past(req_data.in_byte) && rsp_data.packet_done == $past(req_data.packet_last))
   `OSD_ASSERT_NOW(a_arg_clear, rsp_valid && rsp_data.byte_kind != KIND_ARG && rsp_data.byte_kind != KIND_PAD, rsp_data.arg_number == 4'd0 && rsp_data.arg_type == 8'd0)
   `OSD_ASSERT_NOW(a_backpressure, rsp_valid && rsp_stall, req_stall)

endmodule

bind osc_packet_deframer osd_checker u_checker (.*);

>>> test/osd_label_checker.sv
`timescale 1ns / 100ps
// Checker for the OSC packet deframer: watches both channels, labels each taken byte
// with its own parser copy and compares the labels of each result. Depends on osd_pkg.
module osd_label_checker import osd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  osd_req_type req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  osd_rsp_type rsp_data,
   output int          fail_count,
   output int          pending_count
);
   localparam int NTAGS = DEF_MAX_TAGS;
   localparam int NDEPTH = DEF_MAX_DEPTH;
   localparam logic [55:0] BUNDLE_ID = "#bundle";

   logic [3:0]  mode;
   logic [2:0]  hdr_idx;
   logic [31:0] fcount;
   logic [1:0]  pad_left;
   logic [7:0]  tags [NTAGS];
   logic [4:0]  ntag;
   logic [4:0]  cursor;
   logic [31:0] elem_left [NDEPTH];
   logic [2:0]  level;
   logic [31:0] shreg;
   osd_rsp_type labels_due [$];

   function automatic logic [2:0] size_class(input logic [7:0] t);
      case (t)
         "i", "f", "c", "r", "m": size_class = CLS_FIX4;
         "h", "t", "d":           size_class = CLS_FIX8;
         "s", "S":                size_class = CLS_STR;
         "b":                     size_class = CLS_BLOB;
         default:                 size_class = CLS_NONE;
      endcase
   endfunction

   function automatic logic [4:0] next_sized(input logic [4:0] start);
      for (int j = start; j < ntag && j < NTAGS; j++)
         if (size_class(tags[j]) != CLS_NONE) return 5'(j);
      return ntag;
   endfunction

   task automatic start_args(input logic [4:0] start, inout logic dn);
      logic [4:0] j;
      j = next_sized(start);
      if (j >= ntag || j >= NTAGS) begin
         dn = 1;
         mode = M_SCAN;
         return;
      end
      cursor = j;
      fcount = 0;
      case (size_class(tags[j]))
         CLS_FIX4: begin mode = M_AFIX; fcount = 4; end
         CLS_FIX8: begin mode = M_AFIX; fcount = 8; end
         CLS_STR:  mode = M_ASTR;
         default:  begin mode = M_BSIZE; shreg = 0; end
      endcase
   endtask

   function automatic logic [1:0] scope_close();
      case (mode)
         M_SCAN:  return SE_CLEAN;
         M_ESIZE: return fcount == 0 ? SE_CLEAN : SE_TRUNC;
         M_APAD:  return SE_DONE;
         M_TPAD:  return next_sized(0) >= ntag ? SE_DONE : SE_TRUNC;
         M_ASPAD: return next_sized(cursor + 1) >= ntag ? SE_DONE : SE_TRUNC;
         default: return SE_TRUNC;
      endcase
   endfunction

   task automatic clear_parser();
      mode = M_SCAN; hdr_idx = 0; fcount = 0; pad_left = 0; ntag = 0;
      cursor = 0; level = 0; shreg = 0;
      for (int i = 0; i < NTAGS; i++) tags[i] = 0;
      for (int i = 0; i < NDEPTH; i++) elem_left[i] = 0;
   endtask

   task automatic label_byte(input logic [7:0] b, input logic last, output osd_rsp_type r);
      logic [2:0] d0, kind, flt;
      logic [3:0] argn;
      logic [7:0] argt;
      logic dn, ending, again;
      logic [1:0] code;
      logic [31:0] s, rr;
      d0 = level; kind = KIND_SKIP; flt = FAULT_NONE; argn = 0; argt = 0;
      dn = 0; ending = 0; again = 1;
      if (d0 > 0 && elem_left[d0-1] > 0) begin
         elem_left[d0-1]--;
         if (elem_left[d0-1] == 0) ending = 1;
      end
      for (int p = 0; p < 4 && again; p++) begin
         again = 0;
         if (mode >= M_AFIX && mode <= M_BPAD && cursor < NTAGS) begin
            argn = cursor[3:0];
            argt = tags[cursor];
         end else begin
            argn = 0;
            argt = 0;
         end
         case (mode)
            M_SCAN: begin
               if (b == CH_HASH) begin kind = KIND_BHDR; mode = M_BHDR; hdr_idx = 1; end
               else if (b == CH_SLASH) begin kind = KIND_ADDR; mode = M_ADDR; fcount = 1; end
               else kind = KIND_SKIP;
            end
            M_BHDR: begin
               if (hdr_idx < 7 && b != BUNDLE_ID[8*(6-hdr_idx) +: 8]) begin
                  if (flt == FAULT_NONE) flt = FAULT_BUNDLE;
                  mode = M_SCAN;
                  again = 1;
               end else begin
                  kind = KIND_BHDR;
                  if (hdr_idx >= 7) begin mode = M_TIME; fcount = 0; end
                  else hdr_idx++;
               end
            end
            M_TIME: begin
               kind = KIND_TIME;
               fcount++;
               if (fcount >= 8) begin mode = M_ESIZE; fcount = 0; shreg = 0; end
            end
            M_ESIZE: begin
               kind = KIND_ESIZE;
               shreg = {shreg[23:0], b};
               fcount++;
               if (fcount >= 4) begin
                  s = shreg[31] ? 32'd0 : shreg;
                  rr = (s + 3) & ~32'd3;
                  if (level > 0 && rr > elem_left[level-1]) rr = elem_left[level-1];
                  fcount = 0;
                  shreg = 0;
                  if (rr > 0) begin
                     if (level >= NDEPTH) begin
                        if (flt == FAULT_NONE) flt = FAULT_DEPTH;
                        mode = M_SKIPEL;
                        fcount = rr;
                     end else begin
                        if (level > 0) elem_left[level-1] -= rr;
                        elem_left[level] = rr;
                        level++;
                        mode = M_SCAN;
                     end
                  end
               end
            end
            M_ADDR: begin
               if (b != 0) begin kind = KIND_ADDR; fcount++; end
               else begin
                  kind = KIND_PAD; pad_left = 2'd3 - fcount[1:0]; mode = M_APAD;
               end
            end
            M_APAD: begin
               if (b == 0 && pad_left > 0) begin kind = KIND_PAD; pad_left--; end
               else if (b == CH_COMMA) begin
                  kind = KIND_TAG; mode = M_TAG; fcount = 1; ntag = 0; cursor = 0;
               end else begin dn = 1; mode = M_SCAN; again = 1; end
            end
            M_TAG: begin
               if (b != 0) begin
                  kind = KIND_TAG;
                  fcount++;
                  if (ntag < NTAGS) begin tags[ntag] = b; ntag++; end
                  else if (flt == FAULT_NONE) flt = FAULT_TAGS;
               end else begin
                  kind = KIND_PAD;
                  pad_left = 2'd3 - fcount[1:0];
                  cursor = 0;
                  if (pad_left == 0) start_args(0, dn);
                  else mode = M_TPAD;
               end
            end
            M_TPAD: begin
               if (b == 0 && pad_left > 0) begin
                  kind = KIND_PAD;
                  pad_left--;
                  if (pad_left == 0) start_args(0, dn);
               end else begin start_args(0, dn); again = 1; end
            end
            M_AFIX: begin
               kind = KIND_ARG;
               if (fcount > 0) fcount--;
               if (fcount == 0) start_args(cursor + 1, dn);
            end
            M_ASTR: begin
               if (b != 0) begin kind = KIND_ARG; fcount++; end
               else begin
                  kind = KIND_PAD;
                  pad_left = 2'd3 - fcount[1:0];
                  if (pad_left == 0) start_args(cursor + 1, dn);
                  else mode = M_ASPAD;
               end
            end
            M_ASPAD: begin
               if (b == 0 && pad_left > 0) begin
                  kind = KIND_PAD;
                  pad_left--;
                  if (pad_left == 0) start_args(cursor + 1, dn);
               end else begin start_args(cursor + 1, dn); again = 1; end
            end
            M_BSIZE: begin
               kind = KIND_ARG;
               shreg = {shreg[23:0], b};
               fcount++;
               if (fcount >= 4) begin
                  s = shreg[31] ? 32'd0 : shreg;
                  fcount = s;
                  pad_left = 2'(32'd0 - s);
                  shreg = 0;
                  if (s > 0) mode = M_BDATA;
                  else if (pad_left > 0) mode = M_BPAD;
                  else start_args(cursor + 1, dn);
               end
            end
            M_BDATA: begin
               kind = KIND_ARG;
               if (fcount > 0) fcount--;
               if (fcount == 0) begin
                  if (pad_left > 0) mode = M_BPAD;
                  else start_args(cursor + 1, dn);
               end
            end
            M_BPAD: begin
               kind = KIND_PAD;
               if (pad_left > 0) pad_left--;
               if (pad_left == 0) start_args(cursor + 1, dn);
            end
            M_SKIPEL: begin
               kind = KIND_SKIP;
               if (fcount > 0) fcount--;
               if (fcount == 0) begin mode = M_ESIZE; shreg = 0; end
            end
            default: begin kind = KIND_SKIP; mode = M_SCAN; end
         endcase
      end
      if (kind < KIND_ARG) begin argn = 0; argt = 0; end
      if (ending) begin
         code = scope_close();
         if (code == SE_DONE) dn = 1;
         else if (code == SE_TRUNC && flt == FAULT_NONE) flt = FAULT_TRUNC;
         level = d0 - 1;
         while (level > 0 && elem_left[level-1] == 0) level--;
         mode = M_ESIZE; fcount = 0; shreg = 0; pad_left = 0;
      end
      if (last) begin
         code = scope_close();
         if (code == SE_DONE) dn = 1;
         else if ((code == SE_TRUNC || level > 0) && flt == FAULT_NONE) flt = FAULT_TRUNC;
         clear_parser();
      end
      r = '{out_byte: b, byte_kind: kind, arg_number: argn, arg_type: argt,
            message_done: dn, nest_depth: d0, fault: flt, packet_done: last};
   endtask

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   assign pending_count = labels_due.size();

   always @(posedge clock) begin
      osd_rsp_type e;
      if (reset) begin
         clear_parser();
         labels_due.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (labels_due.size() == 0)
               report("unexpected transaction", 32'(rsp_data), 32'd0);
            else begin
               e = labels_due.pop_front();
               if (rsp_data.out_byte != e.out_byte)
                  report("out_byte", 32'(rsp_data.out_byte), 32'(e.out_byte));
               if (rsp_data.byte_kind != e.byte_kind)
                  report("byte_kind", 32'(rsp_data.byte_kind), 32'(e.byte_kind));
               if (rsp_data.arg_number != e.arg_number)
                  report("arg_number", 32'(rsp_data.arg_number), 32'(e.arg_number));
               if (rsp_data.arg_type != e.arg_type)
                  report("arg_type", 32'(rsp_data.arg_type), 32'(e.arg_type));
               if (rsp_data.message_done != e.message_done)
                  report("message_done", 32'(rsp_data.message_done), 32'(e.message_done));
               if (rsp_data.nest_depth != e.nest_depth)
                  report("nest_depth", 32'(rsp_data.nest_depth), 32'(e.nest_depth));
               if (rsp_data.fault != e.fault)
                  report("fault", 32'(rsp_data.fault), 32'(e.fault));
               if (rsp_data.packet_done != e.packet_done)
                  report("packet_done", 32'(rsp_data.packet_done), 32'(e.packet_done));
            end
         end
         if (req_valid && !req_stall) begin
            label_byte(req_data.in_byte, req_data.packet_last, e);
            labels_due = {labels_due, e};
         end
      end
   end
endmodule

>>> test/osc_packet_deframer_tb.sv
`timescale 1ns / 100ps
// Top of the OSC packet deframer testbench: clock, reset, packet stimulus, verdict.
// Depends on osd_pkg, osc_packet_deframer and osd_label_checker.
module osc_packet_deframer_tb import osd_pkg::*; ();
   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   osd_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   osd_rsp_type rsp_data;
   int          fail_count, pending_count;
   int          cycle_count = 0;
   int          sent_count = 0;
   bit          hold_rsp = 0;
   logic [7:0]  pkt [$];

   always #4 clock = ~clock;

   osc_packet_deframer uut (.*);
   osd_label_checker chk (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // receiver stalls; hold_rsp forces a long hold-off
   always @(posedge clock) begin
      int n;
      if (reset) rsp_stall <= 0;
      else if (hold_rsp) rsp_stall <= 1;
      else begin
         n = $urandom_range(0, 99);
         if (cycle_count % 3000 < 800) rsp_stall <= 0;
         else if (n < 20) rsp_stall <= 1;
         else if (n < 23) rsp_stall <= ($urandom_range(0, 3) != 0);
         else rsp_stall <= 0;
      end
   end

   task automatic pkt_add(input logic [7:0] v);
      pkt = {pkt, v};
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = $urandom_range(0, 99);
      if (gap < 20 && cycle_count % 3000 > 800)
         repeat (gap < 2 ? $urandom_range(10, 30) : $urandom_range(1, 3)) begin
            req_valid <= 0;
            @(posedge clock);
         end
      req_valid <= 1;
      req_data <= '{in_byte: b, packet_last: last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
   endtask

   task automatic send_packet();
      for (int i = 0; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1);
      req_valid <= 0;
      pkt.delete();
   endtask

   task automatic put_str(input string s);
      int n;
      for (int i = 0; i < s.len(); i++) pkt_add(s[i]);
      n = s.len();
      do begin pkt_add(8'h00); n++; end while (n % 4 != 0);
   endtask

   task automatic put32(input logic [31:0] v);
      for (int i = 3; i >= 0; i--) pkt_add(v[8*i +: 8]);
   endtask

   function automatic logic [7:0] rand_tag();
      string t;
      t = "iffcrmhtdsSbbNTI";
      return t[$urandom_range(0, 15)];
   endfunction

   // one message with random address, tags and arguments
   task automatic put_message(input int ntags);
      string a, tg;
      logic [7:0] c;
      int len;
      a = "/";
      repeat ($urandom_range(0, 6)) a = {a, string'(8'($urandom_range(97, 122)))};
      put_str(a);
      tg = ",";
      repeat (ntags) tg = {tg, string'(rand_tag())};
      put_str(tg);
      for (int i = 1; i < tg.len(); i++) begin
         c = tg[i];
         case (c)
            "i", "f", "c", "r", "m": put32($urandom);
            "h", "t", "d": begin put32($urandom); put32($urandom); end
            "s", "S": begin
               a = "";
               repeat ($urandom_range(0, 6)) a = {a, string'(8'($urandom_range(1, 255)))};
               put_str(a);
            end
            "b": begin
               len = $urandom_range(0, 6);
               put32(32'(len));
               repeat (len) pkt_add(8'($urandom));
               while (len % 4 != 0) begin pkt_add(8'h00); len++; end
            end
            default: ;
         endcase
      end
   endtask

   // bundle with nested elements; sizes computed from content
   task automatic put_bundle(input int depth);
      int start, at;
      put_str("#bundle");
      put32($urandom); put32($urandom);
      repeat ($urandom_range(0, 3)) begin
         at = pkt.size();
         put32(0);
         start = pkt.size();
         if (depth > 0 && $urandom_range(0, 2) == 0) put_bundle(depth - 1);
         else put_message($urandom_range(0, 5));
         for (int i = 0; i < 4; i++) pkt[at + i] = 8'((pkt.size() - start) >> (8 * (3 - i)));
      end
   endtask

   task automatic put_noise(input int n);
      repeat (n) pkt_add($urandom_range(0, 3) == 0 ? 8'h00 : 8'($urandom));
   endtask

   initial begin
      int k;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed
      pkt_add(8'hff); pkt_add(8'h00); send_packet();
      put_message(2); send_packet();
      put_str("/a"); put_str(",ihsb"); put32(1); put32(2); put32(3); put_str("x");
      put32(32'hffff_fff0); send_packet();
      put_str("/a"); put_str(",iiiiiiiiiiiiiiiiii"); send_packet();
      put_str("#bux"); send_packet();
      put_str("#bundle"); put32(0); put32(0); put32(0); put32(12); put_message(0); send_packet();
      put_str("#bundle"); put32(1); put32(1); put32(32'h8000_0000); put32(500);
      put_str("/a"); pkt_add(8'h55); send_packet();
      put_str("/ab"); pkt_add("/"); pkt_add(8'h00); send_packet();
      // deep nesting to overflow
      for (int i = 0; i < 6; i++) begin
         put_str("#bundle"); put32(0); put32(0); put32(200 - 24 * i);
      end
      put_noise(20); send_packet();
      // long hold-off: block fills and stalls its input
      fork
         begin
            hold_rsp = 1;
            repeat (60) @(posedge clock);
            hold_rsp = 0;
         end
         begin put_bundle(2); put_noise(30); send_packet(); end
      join
      // random
      while (sent_count < 1650) begin
         k = $urandom_range(0, 9);
         if (k < 4) put_message($urandom_range(0, 20));
         else if (k < 8) put_bundle($urandom_range(0, 5));
         else if (k < 9) put_noise($urandom_range(1, 12));
         else begin
            put_bundle(3);
            repeat ($urandom_range(1, 4)) void'(pkt.pop_back());
            pkt[$urandom_range(0, pkt.size() - 1)] = 8'($urandom);
         end
         if (pkt.size() == 0) pkt_add(8'($urandom));
         send_packet();
      end
      while (pending_count != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end
endmodule
